// File: hw/rtl/mexp_pkg.sv
// mexp_pkg: shared types and constants for the modular exponentiation core
// used by mexp_ctrl, mexp_datapath and modular_exponentiation_core; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

   // width of the base, exponent, modulus and power_mod fields on the ports
   localparam int FIELD_W = 32;

   // default operand width of the datapath
   localparam int WIDTH_DEFAULT = 32;

   typedef struct packed {
      logic [FIELD_W-1:0] base;
      logic [FIELD_W-1:0] exponent;
      logic [FIELD_W-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] power_mod;
      logic               modulus_zero;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SQUARE,
      ST_MULTIPLY,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic reduce_step;
      logic reduce_last;
      logic exp_shift;
      logic mul_step;
      logic mul_first;
      logic mul_last;
      logic mul_base;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic exp_msb;
      logic mod_zero;
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/modular_exponentiation_core.sv
// modular_exponentiation_core: top level, base^exponent mod modulus
// depends on mexp_pkg, mexp_ctrl and mexp_datapath
`timescale 1ns / 1ps
`default_nettype none

// Computes base^exponent mod modulus by left-to-right square-and-multiply. Drive
// req_item and pulse start while busy is low; the item is taken on that edge. One
// item is worked on at a time. The result appears on rsp_item for exactly one
// cycle with rsp_valid high and cannot be held off, so the receiver must take it
// then. Each modular product goes through a bit-serial double-and-add multiplier
// that handles one bit per cycle. An item passes through base reduction (which
// also skips leading exponent zeros), then one square per scanned exponent bit,
// from the top set bit down, and one multiply per set bit, then the result state.
// A zero modulus returns power_mod = 0 with modulus_zero set, going from base
// reduction straight to the result. Inputs are taken modulo 2^WIDTH.
module modular_exponentiation_core #(
   parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  mexp_pkg::req_type req_item,
   output logic              rsp_valid,
   output mexp_pkg::rsp_type rsp_item
);

   mexp_pkg::cmd_type    cmd;
   mexp_pkg::status_type status;

   mexp_ctrl #(
      .WIDTH(WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   mexp_datapath #(
      .WIDTH(WIDTH)
   ) u_datapath (
      .clock    (clock),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

// File: hw/rtl/mexp_datapath.sv
// mexp_datapath: operand registers, base reduction and bit-serial modular multiplier
// depends on mexp_pkg; driven by mexp_ctrl through cmd_type / status_type
`timescale 1ns / 1ps
`default_nettype none

module mexp_datapath #(
   parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
   input  wire                  clock,
   input  mexp_pkg::req_type    req_item,
   input  mexp_pkg::cmd_type    cmd,
   output mexp_pkg::status_type status,
   output mexp_pkg::rsp_type    rsp_item
);

   localparam int SUM_W = WIDTH + 2;

   logic [WIDTH-1:0] base_ff;
   logic [WIDTH-1:0] exp_ff;
   logic [WIDTH-1:0] mod_ff;
   logic [WIDTH-1:0] acc_ff;
   logic [WIDTH-1:0] prod_ff;
   logic [WIDTH-1:0] mult_ff;

   logic [WIDTH-1:0] mod_load;
   logic             acc_init;
   logic [WIDTH:0]   red_sum;
   logic [WIDTH:0]   red_diff;
   logic [WIDTH-1:0] red_next;
   logic [WIDTH-1:0] prod_cur;
   logic [WIDTH-1:0] y_cur;
   logic [WIDTH-1:0] x_cur;
   logic [SUM_W-1:0] mul_sum;
   logic [SUM_W-1:0] mod_one;
   logic [SUM_W-1:0] mod_two;
   logic [SUM_W-1:0] sub_one;
   logic [SUM_W-1:0] sub_two;
   logic [WIDTH-1:0] mul_next;

   always_comb begin
      mod_load = WIDTH'(req_item.modulus);
      // 1 mod m is 0 only when m is one
      acc_init = (mod_load > WIDTH'(1));

      // restoring remainder, one base bit per cycle
      red_sum  = {prod_ff, base_ff[WIDTH-1]};
      red_diff = red_sum - {1'b0, mod_ff};
      red_next = (red_sum >= {1'b0, mod_ff}) ? red_diff[WIDTH-1:0] : red_sum[WIDTH-1:0];

      // double-and-add step: 2*p + x stays below 3*m
      prod_cur = cmd.mul_first ? '0 : prod_ff;
      y_cur    = cmd.mul_first ? acc_ff : mult_ff;
      x_cur    = cmd.mul_base ? base_ff : acc_ff;
      mul_sum  = {1'b0, prod_cur, 1'b0} + (y_cur[WIDTH-1] ? SUM_W'(x_cur) : '0);
      mod_one  = SUM_W'(mod_ff);
      mod_two  = {1'b0, mod_ff, 1'b0};
      sub_one  = mul_sum - mod_one;
      sub_two  = mul_sum - mod_two;
      if (mul_sum >= mod_two) begin
         mul_next = sub_two[WIDTH-1:0];
      end else if (mul_sum >= mod_one) begin
         mul_next = sub_one[WIDTH-1:0];
      end else begin
         mul_next = mul_sum[WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff <= WIDTH'(req_item.base);
         exp_ff  <= WIDTH'(req_item.exponent);
         mod_ff  <= mod_load;
         acc_ff  <= {{(WIDTH-1){1'b0}}, acc_init};
         prod_ff <= '0;
      end else if (cmd.reduce_step) begin
         prod_ff <= red_next;
         if (cmd.reduce_last) begin
            base_ff <= red_next;
         end else begin
            base_ff <= {base_ff[WIDTH-2:0], 1'b0};
         end
      end else if (cmd.mul_step) begin
         prod_ff <= mul_next;
         mult_ff <= {y_cur[WIDTH-2:0], 1'b0};
         if (cmd.mul_last) begin
            acc_ff <= mul_next;
         end
      end

      if (cmd.exp_shift && !cmd.load) begin
         exp_ff <= {exp_ff[WIDTH-2:0], 1'b0};
      end
   end

   always_comb begin
      status.exp_msb  = exp_ff[WIDTH-1];
      status.mod_zero = (mod_ff == '0);
      rsp_item.modulus_zero = status.mod_zero;
      rsp_item.power_mod    = status.mod_zero ? '0 : mexp_pkg::FIELD_W'(acc_ff);
   end

endmodule

`default_nettype wire

// File: hw/rtl/mexp_ctrl.sv
// mexp_ctrl: sequencer for base reduction, exponent scan and square / multiply passes
// depends on mexp_pkg; commands mexp_datapath
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl #(
   parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  mexp_pkg::status_type status,
   output mexp_pkg::cmd_type    cmd
);

   localparam int CNT_W  = $clog2(WIDTH);
   localparam int BITS_W = $clog2(WIDTH + 1);

   mexp_pkg::state_type state_ff;
   mexp_pkg::state_type state_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   logic [BITS_W-1:0]   bits_ff;
   logic [BITS_W-1:0]   bits_in;
   logic                cnt_last;

   assign cnt_last = (cnt_ff == CNT_W'(WIDTH - 1));

   // outputs
   always_comb begin
      cmd       = '0;
      busy      = (state_ff != mexp_pkg::ST_IDLE);
      rsp_valid = (state_ff == mexp_pkg::ST_DONE);
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         mexp_pkg::ST_REDUCE: begin
            cmd.reduce_step = 1'b1;
            cmd.reduce_last = cnt_last;
            // skip leading zeros of the exponent meanwhile
            cmd.exp_shift   = (bits_ff != '0) && !status.exp_msb;
         end
         mexp_pkg::ST_SQUARE: begin
            cmd.mul_step  = 1'b1;
            cmd.mul_first = (cnt_ff == '0);
            cmd.mul_last  = cnt_last;
            cmd.exp_shift = cnt_last && !status.exp_msb;
         end
         mexp_pkg::ST_MULTIPLY: begin
            cmd.mul_step  = 1'b1;
            cmd.mul_first = (cnt_ff == '0);
            cmd.mul_last  = cnt_last;
            cmd.mul_base  = 1'b1;
            cmd.exp_shift = cnt_last;
         end
         default: begin
         end
      endcase
   end

   // next state and counters
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CNT_W'(1);
      bits_in  = cmd.exp_shift ? (bits_ff - BITS_W'(1)) : bits_ff;
      case (state_ff)
         mexp_pkg::ST_IDLE: begin
            cnt_in  = '0;
            bits_in = BITS_W'(WIDTH);
            if (start) begin
               state_in = mexp_pkg::ST_REDUCE;
            end
         end
         mexp_pkg::ST_REDUCE: begin
            if (status.mod_zero) begin
               state_in = mexp_pkg::ST_DONE;
            end else if (cnt_last) begin
               cnt_in   = '0;
               state_in = (bits_in == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_SQUARE;
            end
         end
         mexp_pkg::ST_SQUARE: begin
            if (cnt_last) begin
               cnt_in = '0;
               if (status.exp_msb) begin
                  state_in = mexp_pkg::ST_MULTIPLY;
               end else begin
                  state_in = (bits_in == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_SQUARE;
               end
            end
         end
         mexp_pkg::ST_MULTIPLY: begin
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = (bits_in == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_SQUARE;
            end
         end
         mexp_pkg::ST_DONE: begin
            state_in = mexp_pkg::ST_IDLE;
         end
         default: begin
            state_in = mexp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
         cnt_ff   <= '0;
         bits_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         bits_ff  <= bits_in;
      end
   end

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_start_taken: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == mexp_pkg::ST_REDUCE))
      else $error("accepted item did not start base reduction");

   a_bits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mexp_pkg::ST_SQUARE || state_ff == mexp_pkg::ST_MULTIPLY)
      |-> (bits_ff != '0))
      else $error("square or multiply pass with no exponent bits left");

   a_multiply_after_square: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == mexp_pkg::ST_MULTIPLY)
      |-> $past(state_ff == mexp_pkg::ST_SQUARE) && $past(status.exp_msb))
      else $error("multiply pass not preceded by a square on a set bit");

endmodule

`default_nettype wire
